/* design/dtmf_goertzel_command_decoder_assert.svh */
// assertion macros for the dtmf command decoder checker
// no dependencies; included by the checker file
`ifndef DTMF_GOERTZEL_COMMAND_DECODER_ASSERT_SVH
`define DTMF_GOERTZEL_COMMAND_DECODER_ASSERT_SVH

// implication checked on every rising edge outside reset
`define DGCD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define DGCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/dgcd_pkg.sv */
// shared constants, types and tables of the dtmf command decoder
// no dependencies; imported by the front end, back end and top level
package dgcd_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int ACC_BITS_DEF    = 32;
  localparam int DC_SHIFT_DEF    = 6;

  localparam int QSHIFT      = 14;
  localparam int NTONES      = 8;
  localparam int TONE_BITS   = 3;
  localparam int COEF_BITS   = 16;
  localparam int ENERGY_BITS = 40;
  localparam int AGE_BITS    = 18;
  localparam int CODE_BITS   = 5;
  localparam int CMD_BITS    = 4;
  localparam int CNT_BITS    = 4;
  localparam int FRAME_BITS  = 8;
  localparam int POW_BITS    = 51;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 40;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_ENERGY     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STABLE_NEEDED  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_NEEDED = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PREFIX_TIMEOUT = 3'd4;

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_NONE    = 4'd0;
  localparam logic [CMD_BITS-1:0] CMD_START   = 4'd1;
  localparam logic [CMD_BITS-1:0] CMD_STOP    = 4'd2;
  localparam logic [CMD_BITS-1:0] CMD_ID      = 4'd3;
  localparam logic [CMD_BITS-1:0] CMD_ONCE    = 4'd4;
  localparam logic [CMD_BITS-1:0] CMD_FOX     = 4'd5;
  localparam logic [CMD_BITS-1:0] CMD_WARBLE  = 4'd6;
  localparam logic [CMD_BITS-1:0] CMD_SWEEP   = 4'd7;
  localparam logic [CMD_BITS-1:0] CMD_RESTART = 4'd8;
  localparam logic [CMD_BITS-1:0] CMD_CANCEL  = 4'd9;

  localparam logic [CODE_BITS-1:0] CODE_NONE = 5'd0;
  localparam logic [CODE_BITS-1:0] CODE_STAR = 5'd13;

  typedef struct packed {
    logic [FRAME_BITS-1:0]  frame_length;
    logic [ENERGY_BITS-1:0] min_energy;
    logic [CNT_BITS-1:0]    stable_needed;
    logic [CNT_BITS-1:0]    release_needed;
    logic [AGE_BITS-1:0]    prefix_timeout;
  } cfg_t;

  // result word, first field in the highest bits
  typedef struct packed {
    logic                 armed;
    logic [CMD_BITS-1:0]  command_code;
    logic                 command_ready;
    logic [CODE_BITS-1:0] held_digit;
    logic                 latch_event;
    logic [CODE_BITS-1:0] frame_digit;
  } res_t;

  // q14 goertzel coefficients, four row tones then four column tones
  function automatic logic [COEF_BITS-1:0] tone_coef(input logic [TONE_BITS-1:0] t);
    logic [COEF_BITS-1:0] c;
    unique case (t)
      3'd0: c = 16'd27980;
      3'd1: c = 16'd26956;
      3'd2: c = 16'd25701;
      3'd3: c = 16'd24154;
      3'd4: c = 16'd19073;
      3'd5: c = 16'd16325;
      3'd6: c = 16'd13085;
      3'd7: c = 16'd9279;
    endcase
    return c;
  endfunction

  // digit code to command after the star prefix
  function automatic logic [CMD_BITS-1:0] command_of(input logic [CODE_BITS-1:0] code);
    logic [CMD_BITS-1:0] c;
    case (code)
      5'd1:    c = CMD_START;
      5'd2:    c = CMD_ID;
      5'd3:    c = CMD_RESTART;
      5'd5:    c = CMD_ONCE;
      5'd6:    c = CMD_FOX;
      5'd7:    c = CMD_WARBLE;
      5'd9:    c = CMD_SWEEP;
      5'd14:   c = CMD_STOP;
      5'd15:   c = CMD_CANCEL;
      default: c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

/* design/dgcd_queue.sv */
// small first-in first-out queue between the front and the back
// depends on nothing but its parameters
module dgcd_queue #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  logic                do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* design/dgcd_front.sv */
// front end: takes samples, tracks and removes dc, classifies keyed words
// depends on dgcd_pkg
module dgcd_front #(
  parameter int SAMPLE_BITS = 12,
  parameter int DC_SHIFT    = 6,
  parameter int TDATA_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TDATA_BITS-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [SAMPLE_BITS+1:0] q_data
);

  import dgcd_pkg::*;

  localparam int CW = SAMPLE_BITS + 1;

  logic [SAMPLE_BITS-1:0] dc_r, dc_nxt, s;
  logic signed [CW-1:0]   diff, step, centered;

  assign s = in_tdata[SAMPLE_BITS-1:0];

  // first-order dc tracker
  always_comb begin
    diff     = $signed({1'b0, s}) - $signed({1'b0, dc_r});
    step     = diff >>> DC_SHIFT;
    dc_nxt   = dc_r + step[SAMPLE_BITS-1:0];
    centered = $signed({1'b0, s}) - $signed({1'b0, dc_nxt});
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign q_data    = in_tuser ? {1'b1, {CW{1'b0}}} : {1'b0, centered};

  // dc estimate is kept across keyed words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    end else if (q_push && !in_tuser) begin
      dc_r <= dc_nxt;
    end
  end

endmodule

/* design/dgcd_back.sv */
// back end: eight goertzel filters on one shared multiplier, frame decode,
// digit debounce and the star command layer; depends on dgcd_pkg
module dgcd_back #(
  parameter int SAMPLE_BITS = 12,
  parameter int ACC_BITS    = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dgcd_pkg::cfg_t         cfg,
  input  logic                   q_empty,
  input  logic [SAMPLE_BITS+1:0] q_data,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output dgcd_pkg::res_t         res
);

  import dgcd_pkg::*;

  localparam int CW = SAMPLE_BITS + 1;
  localparam int PW = ACC_BITS + COEF_BITS + 1;
  localparam int QW = PW + 2;
  localparam int LW = 41;
  localparam int SW = 68;
  localparam logic signed [QW-1:0] ACC_MAX_Q = QW'((64'sd1 <<< (ACC_BITS - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] ACC_MIN_Q = -ACC_MAX_Q - QW'(1);
  localparam logic signed [LW-1:0] P_LIM     = 41'sd1 <<< 24;
  localparam logic [AGE_BITS-1:0]  AGE_MAX   = '1;
  localparam logic [POW_BITS-1:0]  POW_CAP   = POW_BITS'(1) << 50;

  typedef enum logic [3:0] {
    S_IDLE, S_TMUL, S_TACC, S_PAA, S_PBB, S_PCA, S_PLO, S_PHI, S_PSUM,
    S_TEST, S_EMIT
  } state_t;

  state_t                     state_r;
  logic [TONE_BITS-1:0]       tone_r;
  logic signed [CW-1:0]       cent_r;
  logic signed [ACC_BITS-1:0] recent_r [NTONES];
  logic signed [ACC_BITS-1:0] older_r  [NTONES];
  logic [ENERGY_BITS-1:0]     energy_r;
  logic [FRAME_BITS-1:0]      idx_r;
  logic signed [PW-1:0]       prod_r;
  logic signed [49:0]         m_aa_r, m_bb_r;
  logic signed [41:0]         m_ca_r;
  logic signed [45:0]         m_lo_r;
  logic signed [46:0]         m_hi_r;
  logic [1:0]                 best_i_r [2];
  logic [POW_BITS-1:0]        best_p_r [2];
  logic [POW_BITS-1:0]        sec_p_r  [2];
  logic [CODE_BITS-1:0]       digit_r, cand_r, latched_r;
  logic [CNT_BITS-1:0]        stable_r, release_r;
  logic                       prefix_on_r;
  logic [AGE_BITS-1:0]        age_r;
  logic [CMD_BITS-1:0]        pending_r;
  logic                       out_valid_r;
  res_t                       res_r;

  // sample path signals
  logic signed [CW-1:0]       q_cent;
  logic                       q_keyed;
  logic [2*CW-1:0]            sq;
  logic [ENERGY_BITS:0]       esum;
  logic [COEF_BITS-1:0]       coef;
  logic signed [ACC_BITS-1:0] a_sel, b_sel;
  logic signed [QW-1:0]       q0;
  logic signed [ACC_BITS-1:0] q0_sat;
  logic [FRAME_BITS-1:0]      idx_inc;

  // power path signals
  logic signed [LW-1:0]       a_w, b_w;
  logic signed [24:0]         a25, b25;
  logic                       big;
  logic signed [SW-1:0]       cab, pwr_s;
  logic [POW_BITS-1:0]        pwr;
  logic                       grp;
  logic [1:0]                 pos;

  // frame test signals
  logic [55:0]                e20, rc_sum;
  logic                       fail;

  // debounce next values
  logic [CODE_BITS-1:0]       cand_nxt, latched_nxt;
  logic [CNT_BITS-1:0]        stable_nxt, release_nxt;
  logic                       on_nxt, latch_ev, ready;
  logic [AGE_BITS-1:0]        age_nxt;
  logic [CMD_BITS-1:0]        pending_nxt, cmd;
  logic                       out_free;

  assign q_keyed    = q_data[CW];
  assign q_cent     = $signed(q_data[CW-1:0]);
  assign q_pop      = (state_r == S_IDLE) && !q_empty;
  assign out_tvalid = out_valid_r;
  assign res        = res_r;
  assign out_free   = !out_valid_r || out_tready;

  // energy and filter datapath
  always_comb begin
    sq      = (2*CW)'(q_cent) * (2*CW)'(q_cent);
    esum    = {1'b0, energy_r} + (ENERGY_BITS+1)'(sq);
    coef    = tone_coef(tone_r);
    a_sel   = recent_r[tone_r];
    b_sel   = older_r[tone_r];
    q0      = QW'(prod_r >>> QSHIFT) + QW'(cent_r) - QW'(b_sel);
    if (q0 > ACC_MAX_Q) begin
      q0_sat = ACC_BITS'(ACC_MAX_Q);
    end else if (q0 < ACC_MIN_Q) begin
      q0_sat = ACC_BITS'(ACC_MIN_Q);
    end else begin
      q0_sat = q0[ACC_BITS-1:0];
    end
    idx_inc = idx_r + 1'b1;
  end

  // tone power datapath
  always_comb begin
    a_w   = LW'(a_sel);
    b_w   = LW'(b_sel);
    a25   = $signed(a_w[24:0]);
    b25   = $signed(b_w[24:0]);
    big   = (a_w >= P_LIM) || (a_w <= -P_LIM) || (b_w >= P_LIM) || (b_w <= -P_LIM);
    cab   = (SW'(m_hi_r) <<< 20) + SW'(m_lo_r);
    pwr_s = SW'(m_aa_r) + SW'(m_bb_r) - (cab >>> QSHIFT);
    if (big) begin
      pwr = POW_CAP;
    end else if (pwr_s < 0) begin
      pwr = '0;
    end else begin
      pwr = pwr_s[POW_BITS-1:0];
    end
    grp = tone_r[2];
    pos = tone_r[1:0];
  end

  // minimum energy, dominance, twist and energy share tests
  always_comb begin
    e20    = 56'({energy_r, 4'b0}) + 56'({energy_r, 2'b0});
    rc_sum = 56'(best_p_r[0]) + 56'(best_p_r[1]);
    fail   = (energy_r < cfg.min_energy) ||
             (56'(best_p_r[0]) < 56'({sec_p_r[0], 2'b0})) ||
             (56'(best_p_r[1]) < 56'({sec_p_r[1], 2'b0})) ||
             (56'(best_p_r[0]) > 56'({best_p_r[1], 3'b0})) ||
             (56'(best_p_r[1]) > 56'({best_p_r[0], 3'b0})) ||
             (rc_sum < e20);
  end

  // debounce and command layer
  always_comb begin
    cand_nxt    = cand_r;
    latched_nxt = latched_r;
    stable_nxt  = stable_r;
    release_nxt = release_r;
    on_nxt      = prefix_on_r;
    age_nxt     = age_r;
    pending_nxt = pending_r;
    latch_ev    = 1'b0;
    ready       = 1'b0;
    cmd         = CMD_NONE;
    if (digit_r == CODE_NONE) begin
      cand_nxt   = CODE_NONE;
      stable_nxt = '0;
      if (latched_r != CODE_NONE) begin
        release_nxt = release_r + 1'b1;
        if (release_nxt >= cfg.release_needed) begin
          latched_nxt = CODE_NONE;
          release_nxt = '0;
          if (pending_r != CMD_NONE) begin
            ready       = 1'b1;
            cmd         = pending_r;
            pending_nxt = CMD_NONE;
          end
        end
      end
    end else begin
      release_nxt = '0;
      if (digit_r != cand_r) begin
        cand_nxt   = digit_r;
        stable_nxt = CNT_BITS'(1);
      end else if (stable_r < cfg.stable_needed) begin
        stable_nxt = stable_r + 1'b1;
      end
      if (stable_nxt == cfg.stable_needed && digit_r != latched_r) begin
        latched_nxt = digit_r;
        latch_ev    = 1'b1;
        // prefix expiry is only looked at when a digit latches
        if (prefix_on_r && age_r >= cfg.prefix_timeout) begin
          on_nxt = 1'b0;
        end
        if (digit_r == CODE_STAR) begin
          on_nxt      = 1'b1;
          age_nxt     = '0;
          pending_nxt = CMD_NONE;
        end else if (on_nxt) begin
          on_nxt      = 1'b0;
          pending_nxt = command_of(digit_r);
        end
      end
    end
  end

  // sequencer with all state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tone_r      <= '0;
      energy_r    <= '0;
      idx_r       <= '0;
      cand_r      <= CODE_NONE;
      latched_r   <= CODE_NONE;
      stable_r    <= '0;
      release_r   <= '0;
      prefix_on_r <= 1'b0;
      age_r       <= '0;
      pending_r   <= CMD_NONE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NTONES; i++) begin
        recent_r[i] <= '0;
        older_r[i]  <= '0;
      end
    end else begin
      // the emit state sets the flag again when it loads a new word
      if (out_valid_r && out_tready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_keyed) begin
              // transmitter keyed: clear the detector
              energy_r    <= '0;
              idx_r       <= '0;
              cand_r      <= CODE_NONE;
              latched_r   <= CODE_NONE;
              stable_r    <= '0;
              release_r   <= '0;
              prefix_on_r <= 1'b0;
              age_r       <= '0;
              pending_r   <= CMD_NONE;
              for (int i = 0; i < NTONES; i++) begin
                recent_r[i] <= '0;
                older_r[i]  <= '0;
              end
            end else begin
              if (prefix_on_r && age_r != AGE_MAX) begin
                age_r <= age_r + 1'b1;
              end
              energy_r <= esum[ENERGY_BITS] ? '1 : esum[ENERGY_BITS-1:0];
              cent_r   <= q_cent;
              tone_r   <= '0;
              state_r  <= S_TMUL;
            end
          end
        end
        S_TMUL: begin
          prod_r  <= $signed({1'b0, coef}) * a_sel;
          state_r <= S_TACC;
        end
        S_TACC: begin
          older_r[tone_r]  <= a_sel;
          recent_r[tone_r] <= q0_sat;
          tone_r           <= tone_r + 1'b1;
          if (tone_r == TONE_BITS'(NTONES - 1)) begin
            if (idx_inc == cfg.frame_length) begin
              idx_r   <= '0;
              state_r <= S_PAA;
            end else begin
              idx_r   <= idx_inc;
              state_r <= S_IDLE;
            end
          end else begin
            state_r <= S_TMUL;
          end
        end
        S_PAA: begin
          m_aa_r  <= a25 * a25;
          state_r <= S_PBB;
        end
        S_PBB: begin
          m_bb_r  <= b25 * b25;
          state_r <= S_PCA;
        end
        S_PCA: begin
          m_ca_r  <= $signed({1'b0, coef}) * a25;
          state_r <= S_PLO;
        end
        S_PLO: begin
          m_lo_r  <= $signed({1'b0, m_ca_r[19:0]}) * b25;
          state_r <= S_PHI;
        end
        S_PHI: begin
          m_hi_r  <= $signed(m_ca_r[41:20]) * b25;
          state_r <= S_PSUM;
        end
        S_PSUM: begin
          // running best and second best within the row or column group
          if (pos == 2'd0) begin
            best_i_r[grp] <= pos;
            best_p_r[grp] <= pwr;
          end else if (pwr > best_p_r[grp]) begin
            sec_p_r[grp]  <= best_p_r[grp];
            best_i_r[grp] <= pos;
            best_p_r[grp] <= pwr;
          end else if (pos == 2'd1 || pwr > sec_p_r[grp]) begin
            sec_p_r[grp] <= pwr;
          end
          recent_r[tone_r] <= '0;
          older_r[tone_r]  <= '0;
          tone_r           <= tone_r + 1'b1;
          state_r          <= (tone_r == TONE_BITS'(NTONES - 1)) ? S_TEST : S_PAA;
        end
        S_TEST: begin
          digit_r  <= fail ? CODE_NONE :
                      CODE_BITS'({best_i_r[0], best_i_r[1]}) + CODE_BITS'(1);
          energy_r <= '0;
          state_r  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            cand_r      <= cand_nxt;
            latched_r   <= latched_nxt;
            stable_r    <= stable_nxt;
            release_r   <= release_nxt;
            prefix_on_r <= on_nxt;
            age_r       <= age_nxt;
            pending_r   <= pending_nxt;
            res_r.frame_digit   <= digit_r;
            res_r.latch_event   <= latch_ev;
            res_r.held_digit    <= latched_nxt;
            res_r.command_ready <= ready;
            res_r.command_code  <= cmd;
            res_r.armed         <= on_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/dtmf_goertzel_command_decoder.sv */
// top level of the dtmf goertzel command decoder: configuration registers,
// front end, word queue and back end; depends on dgcd_pkg and its submodules
//
//  channel  | dir | handshake             | content
//  in_*     | in  | in_tvalid/in_tready   | tdata: sample; tuser: keyed
//  out_*    | out | out_tvalid/out_tready | tdata: one result per frame end
//  cfg_*    | in  | cfg_we                | register index and write data
//
// the back end pops a sample word in the idle state, then runs a multiply and
// an accumulate state for each of the eight tones on the shared filter
// multiplier; a frame end adds power states per tone, then a test and an
// emit state; a keyed word is handled in the idle state; the front takes
// one word a cycle into a four-word queue and stalls only when it is full
// reset is synchronous and active low; a stalled result holds the back end
module dtmf_goertzel_command_decoder #(
  parameter int SAMPLE_BITS = dgcd_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = dgcd_pkg::ACC_BITS_DEF,
  parameter int DC_SHIFT    = dgcd_pkg::DC_SHIFT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // sample, zero padding
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  // keyed
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // frame_digit, latch_event, held_digit, command_ready, command_code, armed
  output logic [23:0]                          out_tdata,
  input  logic                                 cfg_we,
  input  logic [dgcd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [dgcd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  import dgcd_pkg::*;

  localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int QW         = SAMPLE_BITS + 2;

  cfg_t            cfg_r;
  logic            q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]   q_wdata, q_rdata;
  res_t            res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_length   <= 8'd205;
      cfg_r.min_energy     <= 40'd100000;
      cfg_r.stable_needed  <= 4'd3;
      cfg_r.release_needed <= 4'd2;
      cfg_r.prefix_timeout <= 18'd24000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_LENGTH:   cfg_r.frame_length   <= cfg_wdata[FRAME_BITS-1:0];
        CFG_MIN_ENERGY:     cfg_r.min_energy     <= cfg_wdata[ENERGY_BITS-1:0];
        CFG_STABLE_NEEDED:  cfg_r.stable_needed  <= cfg_wdata[CNT_BITS-1:0];
        CFG_RELEASE_NEEDED: cfg_r.release_needed <= cfg_wdata[CNT_BITS-1:0];
        CFG_PREFIX_TIMEOUT: cfg_r.prefix_timeout <= cfg_wdata[AGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  dgcd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DC_SHIFT    (DC_SHIFT),
    .TDATA_BITS  (TDATA_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  dgcd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  dgcd_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res)
  );

  assign out_tdata = {7'b0, res};

endmodule

/* design/dgcd_checker.sv */
// port-level checks of the dtmf command decoder, bound to the top level
// depends on dtmf_goertzel_command_decoder_assert.svh
`include "dtmf_goertzel_command_decoder_assert.svh"

module dgcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result word holds
  `DGCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // command code only alongside a released command
  `DGCD_ASSERT_IMP(a_cmd_zero, clk, rst_n, out_tvalid && !out_tdata[11], out_tdata[15:12] == 4'd0, "command code without command ready")

  // a fresh latch holds this frame's digit
  `DGCD_ASSERT_IMP(a_latch_digit, clk, rst_n, out_tvalid && out_tdata[5], out_tdata[10:6] == out_tdata[4:0] && out_tdata[4:0] != 5'd0, "latch does not match frame digit")

  // a command is released only on an empty frame that drops the digit
  `DGCD_ASSERT_IMP(a_cmd_release, clk, rst_n, out_tvalid && out_tdata[11], out_tdata[10:6] == 5'd0 && out_tdata[4:0] == 5'd0 && out_tdata[15:12] != 4'd0, "command outside a release")

endmodule

bind dtmf_goertzel_command_decoder dgcd_checker u_dgcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
